### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, ignored while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/cidm_pkg.sv
// types and constants of the can id payload monitor
`timescale 1ns / 1ps

package cidm_pkg;

   localparam int ID_W      = 11;
   localparam int CSR_IDX_W = 3;
   localparam int MAX_SLOTS = 8;

   localparam logic [1:0] KIND_OBSERVE = 2'd0;
   localparam logic [1:0] KIND_CLEAR   = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;

   localparam logic [3:0] MAX_LEN     = 4'd8;
   localparam logic [7:0] ALL_CHANGED = 8'hFF;

   localparam logic [ID_W-1:0] TARGET_ID_RESET [MAX_SLOTS] = '{
      11'h101, 11'h107, 11'h18D, 11'h1B0, 11'h1B1, 11'h2BA, 11'h37F, 11'h4AD
   };

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  channel;
      logic        extended;
      logic [28:0] frame_id;
      logic [3:0]  frame_length;
      logic [63:0] payload;
      logic [31:0] time_ms;
      logic [2:0]  read_slot;
   } req_type;

   typedef struct packed {
      logic        slot_matched;
      logic [2:0]  slot;
      logic [31:0] frame_count;
      logic [31:0] last_time_ms;
      logic [3:0]  stored_length;
      logic [63:0] first_bytes;
      logic [63:0] last_bytes;
      logic [63:0] low_bytes;
      logic [63:0] high_bytes;
      logic [7:0]  changed_mask;
   } rsp_type;

   typedef struct packed {
      logic [31:0] count;
      logic [31:0] last_time;
      logic [3:0]  length;
      logic [63:0] first_bytes;
      logic [63:0] last_bytes;
      logic [63:0] low_bytes;
      logic [63:0] high_bytes;
      logic [7:0]  changed_mask;
   } slot_type;

endpackage

### src/can_id_payload_monitor_top.sv
// can id payload monitor: input register, slot update, result register
// a beat passes through the input register and then the result register before its result is valid
// throughput: one beat per cycle while the result is not stalled, set by the slot read-modify-write
// a stalled result holds its register; the input register takes the next beat once it moves
// reset: clears all slot statistics and loads the default target identifiers
`timescale 1ns / 1ps

module can_id_payload_monitor_top #(
   parameter int NUM_SLOTS = 8
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  cidm_pkg::req_type                          req_data,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output cidm_pkg::rsp_type                          rsp_data,
   input  logic                                       csr_we,
   input  logic [cidm_pkg::CSR_IDX_W-1:0]             csr_index,
   input  logic [cidm_pkg::ID_W-1:0]                  csr_wdata
);
   import cidm_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic [ID_W-1:0]  target_ff [NUM_SLOTS];
   slot_type         slot_ff [NUM_SLOTS];
   logic             s1_valid_ff;
   req_type          req_data_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   logic             out_free;
   logic             s1_fire;
   logic [3:0]       len_clamped;
   logic             watch;
   logic [NUM_SLOTS-1:0] hit_vec;
   logic             hit;
   logic [IDX_W-1:0] match_idx;
   logic [IDX_W-1:0] sel_idx;
   logic             read_in_range;
   slot_type         cur_slot;
   slot_type         upd_slot;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign len_clamped = (req_data_ff.frame_length > MAX_LEN) ? MAX_LEN
                                                             : req_data_ff.frame_length;
   assign watch = (req_data_ff.kind == KIND_OBSERVE) && (req_data_ff.channel == 3'd0)
                  && !req_data_ff.extended;

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         hit_vec[i] = (req_data_ff.frame_id[28:ID_W] == '0)
                      && (req_data_ff.frame_id[ID_W-1:0] == target_ff[i]);
      end
   end

   // lowest slot wins on duplicate identifiers
   always_comb begin
      match_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            match_idx = IDX_W'(i);
         end
      end
   end

   assign hit           = watch && (|hit_vec);
   assign read_in_range = 32'(req_data_ff.read_slot) < NUM_SLOTS;
   assign sel_idx       = (req_data_ff.kind == KIND_READ) ? req_data_ff.read_slot[IDX_W-1:0]
                                                          : match_idx;
   assign cur_slot      = slot_ff[sel_idx];

   cidm_slot_upd u_slot_upd (
      .old_slot    (cur_slot),
      .frame_len   (len_clamped),
      .frame_bytes (req_data_ff.payload),
      .frame_time  (req_data_ff.time_ms),
      .new_slot    (upd_slot)
   );

   always_comb begin
      rsp_data_in = '0;
      case (req_data_ff.kind)
         KIND_OBSERVE: begin
            if (hit) begin
               rsp_data_in.slot_matched  = 1'b1;
               rsp_data_in.slot          = 3'(match_idx);
               rsp_data_in.frame_count   = upd_slot.count;
               rsp_data_in.last_time_ms  = upd_slot.last_time;
               rsp_data_in.stored_length = upd_slot.length;
               rsp_data_in.first_bytes   = upd_slot.first_bytes;
               rsp_data_in.last_bytes    = upd_slot.last_bytes;
               rsp_data_in.low_bytes     = upd_slot.low_bytes;
               rsp_data_in.high_bytes    = upd_slot.high_bytes;
               rsp_data_in.changed_mask  = upd_slot.changed_mask;
            end
         end
         KIND_READ: begin
            rsp_data_in.slot = req_data_ff.read_slot;
            if (read_in_range) begin
               rsp_data_in.slot_matched  = (cur_slot.count != 32'd0);
               rsp_data_in.frame_count   = cur_slot.count;
               rsp_data_in.last_time_ms  = cur_slot.last_time;
               rsp_data_in.stored_length = cur_slot.length;
               rsp_data_in.first_bytes   = cur_slot.first_bytes;
               rsp_data_in.last_bytes    = cur_slot.last_bytes;
               rsp_data_in.low_bytes     = cur_slot.low_bytes;
               rsp_data_in.high_bytes    = cur_slot.high_bytes;
               rsp_data_in.changed_mask  = cur_slot.changed_mask;
            end
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   // target identifier registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            target_ff[i] <= TARGET_ID_RESET[i];
         end
      end else if (csr_we && (32'(csr_index) < NUM_SLOTS)) begin
         target_ff[csr_index[IDX_W-1:0]] <= csr_wdata;
      end
   end

   // slot statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ff[i] <= '0;
         end
      end else if (s1_fire) begin
         if (req_data_ff.kind == KIND_CLEAR) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               slot_ff[i] <= '0;
            end
         end else if (hit) begin
            slot_ff[match_idx] <= upd_slot;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         req_data_ff <= req_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### src/cidm_slot_upd.sv
// next statistics of one slot for a matching frame
`timescale 1ns / 1ps

module cidm_slot_upd (
   input  cidm_pkg::slot_type old_slot,
   input  logic [3:0]         frame_len,
   input  logic [63:0]        frame_bytes,
   input  logic [31:0]        frame_time,
   output cidm_pkg::slot_type new_slot
);
   import cidm_pkg::*;

   logic       first_frame;
   logic [7:0] lane_en;
   logic [7:0] nv;
   logic [7:0] lv;
   logic [7:0] mn;
   logic [7:0] mx;

   assign first_frame = (old_slot.count == 32'd0);

   always_comb begin
      new_slot = old_slot;
      if (!first_frame && old_slot.length != frame_len) begin
         new_slot.changed_mask = ALL_CHANGED;
      end
      for (int b = 0; b < 8; b++) begin
         lane_en[b] = 4'(b) < frame_len;
         nv = frame_bytes[8*b +: 8];
         lv = old_slot.last_bytes[8*b +: 8];
         mn = old_slot.low_bytes[8*b +: 8];
         mx = old_slot.high_bytes[8*b +: 8];
         if (lane_en[b]) begin
            if (first_frame) begin
               new_slot.first_bytes[8*b +: 8] = nv;
               new_slot.low_bytes[8*b +: 8]   = nv;
               new_slot.high_bytes[8*b +: 8]  = nv;
            end else begin
               if (lv != nv) begin
                  new_slot.changed_mask[b] = 1'b1;
               end
               new_slot.low_bytes[8*b +: 8]  = (nv < mn) ? nv : mn;
               new_slot.high_bytes[8*b +: 8] = (nv > mx) ? nv : mx;
            end
            new_slot.last_bytes[8*b +: 8] = nv;
         end
      end
      new_slot.length    = frame_len;
      new_slot.count     = old_slot.count + 32'd1;
      new_slot.last_time = frame_time;
   end

endmodule

### src/cidm_checker.sv
// port checker of the can id payload monitor and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cidm_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cidm_pkg::rsp_type rsp_data
);
   import cidm_pkg::*;

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result beat dropped while stalled")
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_data), "stalled result beat changed")
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result valid right after reset")
   `ASSERT_CLK(a_unmatched_count, clock, reset, rsp_valid && !rsp_data.slot_matched |-> rsp_data.frame_count == 32'd0, "unmatched result carries a frame count")
   `ASSERT_CLK(a_len_range, clock, reset, rsp_valid |-> rsp_data.stored_length <= MAX_LEN, "stored length above eight")

endmodule

bind can_id_payload_monitor_top cidm_checker u_cidm_checker (.*);
